// ----- sv/assert_macros.svh -----
// Assertion macros used by the RTL checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FPV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define FPV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FPV_ASSERT(label, clk, rst_n, prop, msg)

`define FPV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/fpv_pkg.sv -----
`timescale 1ns / 1ps

package fpv_pkg;

	localparam int unsigned FRAME_MAX_DEFAULT = 65535;
	localparam int unsigned HEADER_BYTES      = 28;

	localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES      = 32'hFFFFFFFF;
	localparam logic [31:0] MAGIC_RESET   = 32'h52485044;
	localparam logic [31:0] VERSION_RESET = 32'h00000001;

	localparam logic REG_MAGIC   = 1'b0;
	localparam logic REG_VERSION = 1'b1;

	localparam logic [2:0] HDR_MAGIC   = 3'd0;
	localparam logic [2:0] HDR_VERSION = 3'd1;
	localparam logic [2:0] HDR_SIZE    = 3'd2;
	localparam logic [2:0] HDR_FLAGS   = 3'd3;
	localparam logic [2:0] HDR_CRC     = 3'd6;

	typedef enum logic [2:0] {
		ST_VALID       = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_BAD_MAGIC   = 3'd2,
		ST_BAD_VERSION = 3'd3,
		ST_SIZE_ERR    = 3'd4,
		ST_CRC_ERR     = 3'd5
	} status_t;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} beat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- sv/framed_payload_validator.sv -----
`timescale 1ns / 1ps
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | data_byte, last_byte
// out     | out_valid / out_ready| status, payload_length, payload_flags, computed_crc
// cfg     | cfg_we               | cfg_idx, cfg_wdata
//
// One byte per cycle unless a result stalls; a frame's result is registered from its last beat.
// The input register feeds a single pass of header capture, one-byte CRC and status logic
// into the result register.
// Reset (arst_n low) clears frame state and loads the default magic and version.
// A stalled result holds the pipeline; one more beat is taken into the input register.

module framed_payload_validator #(
	parameter int unsigned FRAME_MAX = fpv_pkg::FRAME_MAX_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] payload_length,
	output logic [31:0] payload_flags,
	output logic [31:0] computed_crc
);

	fpv_pkg::beat_t beat;
	logic           advance;

	fpv_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.advance   (advance),
		.beat      (beat)
	);

	fpv_checker #(
		.FRAME_MAX (FRAME_MAX)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.beat           (beat),
		.advance        (advance),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.payload_length (payload_length),
		.payload_flags  (payload_flags),
		.computed_crc   (computed_crc)
	);

endmodule

// ----- sv/fpv_in_stage.sv -----
`timescale 1ns / 1ps

module fpv_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	input  logic            advance,
	output fpv_pkg::beat_t  beat
);

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] data_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign beat = '{valid: valid_s1, last: last_s1, data: data_s1};

endmodule

// ----- sv/fpv_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpv_checker #(
	parameter int unsigned FRAME_MAX = fpv_pkg::FRAME_MAX_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_idx,
	input  logic [31:0]     cfg_wdata,
	input  fpv_pkg::beat_t  beat,
	output logic            advance,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      status,
	output logic [31:0]     payload_length,
	output logic [31:0]     payload_flags,
	output logic [31:0]     computed_crc
);

	localparam int unsigned CW = $clog2(FRAME_MAX + 1);

	logic [31:0] exp_magic_q;
	logic [31:0] exp_version_q;

	logic [CW-1:0] count_q;
	logic [31:0]   magic_q;
	logic [31:0]   version_q;
	logic [31:0]   size_q;
	logic [31:0]   flags_q;
	logic [31:0]   stored_q;
	logic [31:0]   crc_q;

	logic [CW-1:0] count_nxt;
	logic [31:0]   magic_nxt;
	logic [31:0]   version_nxt;
	logic [31:0]   size_nxt;
	logic [31:0]   flags_nxt;
	logic [31:0]   stored_nxt;
	logic [31:0]   crc_nxt;
	logic [31:0]   hdr_val;
	logic [31:0]   crc_final;
	logic          process;

	logic             out_valid_q;
	fpv_pkg::status_t status_q;
	fpv_pkg::status_t status_nxt;
	logic [31:0]      length_q;
	logic [31:0]      flags_out_q;
	logic [31:0]      crc_out_q;

	assign advance = !out_valid_q || out_ready;
	assign process = beat.valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_magic_q   <= fpv_pkg::MAGIC_RESET;
			exp_version_q <= fpv_pkg::VERSION_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				fpv_pkg::REG_MAGIC:   exp_magic_q   <= cfg_wdata;
				fpv_pkg::REG_VERSION: exp_version_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		count_nxt   = count_q;
		magic_nxt   = magic_q;
		version_nxt = version_q;
		size_nxt    = size_q;
		flags_nxt   = flags_q;
		stored_nxt  = stored_q;
		crc_nxt     = crc_q;
		hdr_val     = 32'({24'd0, beat.data} << {count_q[1:0], 3'b000});
		if (count_q < CW'(FRAME_MAX)) begin
			if (count_q < CW'(fpv_pkg::HEADER_BYTES)) begin
				case (count_q[4:2])
					fpv_pkg::HDR_MAGIC:   magic_nxt   = magic_q | hdr_val;
					fpv_pkg::HDR_VERSION: version_nxt = version_q | hdr_val;
					fpv_pkg::HDR_SIZE:    size_nxt    = size_q | hdr_val;
					fpv_pkg::HDR_FLAGS:   flags_nxt   = flags_q | hdr_val;
					fpv_pkg::HDR_CRC:     stored_nxt  = stored_q | hdr_val;
					default: ;
				endcase
			end else if ((32'(count_q) - 32'(fpv_pkg::HEADER_BYTES)) < size_q) begin
				crc_nxt = fpv_pkg::crc_byte(crc_q, beat.data);
			end
			count_nxt = count_q + CW'(1);
		end
	end

	assign crc_final = ~crc_nxt;

	always_comb begin
		if (count_nxt < CW'(fpv_pkg::HEADER_BYTES)) begin
			status_nxt = fpv_pkg::ST_TOO_SHORT;
		end else if (magic_nxt != exp_magic_q) begin
			status_nxt = fpv_pkg::ST_BAD_MAGIC;
		end else if (version_nxt != exp_version_q) begin
			status_nxt = fpv_pkg::ST_BAD_VERSION;
		end else if (({1'b0, size_nxt} + 33'(fpv_pkg::HEADER_BYTES)) > 33'(count_nxt)) begin
			status_nxt = fpv_pkg::ST_SIZE_ERR;
		end else if (crc_final != stored_nxt) begin
			status_nxt = fpv_pkg::ST_CRC_ERR;
		end else begin
			status_nxt = fpv_pkg::ST_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			magic_q   <= '0;
			version_q <= '0;
			size_q    <= '0;
			flags_q   <= '0;
			stored_q  <= '0;
			crc_q     <= fpv_pkg::ALL_ONES;
		end else if (process) begin
			if (beat.last) begin
				count_q   <= '0;
				magic_q   <= '0;
				version_q <= '0;
				size_q    <= '0;
				flags_q   <= '0;
				stored_q  <= '0;
				crc_q     <= fpv_pkg::ALL_ONES;
			end else begin
				count_q   <= count_nxt;
				magic_q   <= magic_nxt;
				version_q <= version_nxt;
				size_q    <= size_nxt;
				flags_q   <= flags_nxt;
				stored_q  <= stored_nxt;
				crc_q     <= crc_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= process && beat.last;
		end
	end

	always_ff @(posedge clk) begin
		if (process && beat.last) begin
			status_q    <= status_nxt;
			length_q    <= size_nxt;
			flags_out_q <= flags_nxt;
			crc_out_q   <= crc_final;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign payload_length = length_q;
	assign payload_flags  = flags_out_q;
	assign computed_crc   = crc_out_q;

	`FPV_ASSERT_NEXT(a_last_gives_result, clk, arst_n, process && beat.last, out_valid_q,
		"last beat did not produce a result")
	`FPV_ASSERT_NEXT(a_last_clears_frame, clk, arst_n, process && beat.last,
		count_q == '0 && crc_q == fpv_pkg::ALL_ONES, "frame state not cleared after last beat")
	`FPV_ASSERT(a_count_capped, clk, arst_n, count_q <= CW'(FRAME_MAX),
		"byte count passed frame limit")
	`FPV_ASSERT(a_short_no_crc, clk, arst_n,
		!(out_valid_q && status_q == fpv_pkg::ST_TOO_SHORT) || crc_out_q == 32'd0,
		"short frame reported a payload crc")

endmodule

// ----- test/framed_payload_validator_tb.sv -----
`timescale 1ns / 1ps

module framed_payload_validator_tb;

	localparam int unsigned FRAME_LIMIT = fpv_pkg::FRAME_MAX_DEFAULT;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 400;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} byte_beat_t;

	typedef struct packed {
		fpv_pkg::status_t status;
		logic [31:0]      length;
		logic [31:0]      flags;
		logic [31:0]      crc;
	} frame_verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = fpv_pkg::REG_MAGIC;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [31:0] payload_length;
	logic [31:0] payload_flags;
	logic [31:0] computed_crc;

	framed_payload_validator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.payload_length(payload_length),
		.payload_flags(payload_flags),
		.computed_crc(computed_crc)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// frame checker copy
	logic [31:0] want_magic = fpv_pkg::MAGIC_RESET;
	logic [31:0] want_version = fpv_pkg::VERSION_RESET;
	int unsigned rx_count;
	logic [31:0] hdr_magic, hdr_version, hdr_size, hdr_flags, hdr_crc, crc_reg;
	frame_verdict_t verdicts[$];

	logic [7:0] frame_buf[$];
	byte_beat_t beat_queue[$];
	byte_beat_t tx_beat;
	int unsigned bytes_queued = 0;
	int unsigned frames_queued = 0;
	int unsigned beats_taken = 0;
	int unsigned results_seen = 0;
	int unsigned status_seen[8];
	int unsigned mismatches = 0;
	int idle_cycles = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold = 0;
	bit hold_order = 1'b0;
	bit calm = 1'b0;
	logic in_taken = 1'b0;
	frame_verdict_t want;

	function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		logic fb;
		r = c;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ d[i];
			r = r >> 1;
			if (fb)
				r = r ^ fpv_pkg::CRC_POLY;
		end
		return r;
	endfunction

	task automatic clear_frame_state();
		rx_count = 0;
		hdr_magic = '0;
		hdr_version = '0;
		hdr_size = '0;
		hdr_flags = '0;
		hdr_crc = '0;
		crc_reg = fpv_pkg::ALL_ONES;
	endtask

	task automatic absorb_beat(input logic [7:0] d, input logic lst);
		int unsigned pos;
		logic [31:0] v;
		logic [31:0] crc_out;
		frame_verdict_t res;
		if (rx_count < FRAME_LIMIT) begin
			pos = rx_count;
			if (pos < fpv_pkg::HEADER_BYTES) begin
				v = {24'd0, d} << (8 * (pos % 4));
				case (3'(pos / 4))
					fpv_pkg::HDR_MAGIC: hdr_magic |= v;
					fpv_pkg::HDR_VERSION: hdr_version |= v;
					fpv_pkg::HDR_SIZE: hdr_size |= v;
					fpv_pkg::HDR_FLAGS: hdr_flags |= v;
					fpv_pkg::HDR_CRC: hdr_crc |= v;
					default: ;
				endcase
			end else if (pos - fpv_pkg::HEADER_BYTES < hdr_size) begin
				crc_reg = crc_fold(crc_reg, d);
			end
			rx_count = pos + 1;
		end
		if (lst) begin
			crc_out = ~crc_reg;
			res.length = hdr_size;
			res.flags = hdr_flags;
			res.crc = crc_out;
			if (rx_count < fpv_pkg::HEADER_BYTES)
				res.status = fpv_pkg::ST_TOO_SHORT;
			else if (hdr_magic != want_magic)
				res.status = fpv_pkg::ST_BAD_MAGIC;
			else if (hdr_version != want_version)
				res.status = fpv_pkg::ST_BAD_VERSION;
			else if (64'(hdr_size) + 64'(fpv_pkg::HEADER_BYTES) > 64'(rx_count))
				res.status = fpv_pkg::ST_SIZE_ERR;
			else if (crc_out != hdr_crc)
				res.status = fpv_pkg::ST_CRC_ERR;
			else
				res.status = fpv_pkg::ST_VALID;
			verdicts.push_back(res);
			clear_frame_state();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch: %s at result %0d, got %h, want %h", what, results_seen, got,
				exp_val);
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			frame_buf.push_back(w[8*i +: 8]);
	endtask

	task automatic commit_frame();
		byte_beat_t bt;
		foreach (frame_buf[i]) begin
			bt.data = frame_buf[i];
			bt.last = (i == frame_buf.size() - 1);
			beat_queue.push_back(bt);
		end
		bytes_queued += frame_buf.size();
		frames_queued++;
		frame_buf.delete();
	endtask

	task automatic build_frame(input logic [31:0] magic, input logic [31:0] version,
			input logic [31:0] size, input logic [31:0] flags, input int unsigned carried,
			input logic [31:0] crc_flip, input fill_t fill);
		logic [7:0] body[$];
		logic [31:0] crc;
		logic [7:0] b;
		crc = fpv_pkg::ALL_ONES;
		for (int unsigned i = 0; i < carried; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			body.push_back(b);
			if (i < size)
				crc = crc_fold(crc, b);
		end
		put_word(magic);
		put_word(version);
		put_word(size);
		put_word(flags);
		put_word($urandom);
		put_word($urandom);
		put_word(~crc ^ crc_flip);
		foreach (body[i])
			frame_buf.push_back(body[i]);
		commit_frame();
	endtask

	task automatic build_noise(input int unsigned len, input bit with_header);
		if (with_header) begin
			put_word(want_magic);
			put_word(want_version);
			for (int i = 0; i < 5; i++)
				put_word($urandom);
		end
		while (frame_buf.size() < len)
			frame_buf.push_back(8'($urandom));
		while (frame_buf.size() > len)
			void'(frame_buf.pop_back());
		commit_frame();
	endtask

	function automatic logic [31:0] some_flip();
		return $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31)) : ($urandom | 32'd1);
	endfunction

	task automatic queue_random_frame();
		int unsigned pick;
		int unsigned carried;
		logic [31:0] size;
		logic [31:0] flags;
		pick = $urandom_range(0, 99);
		carried = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 24);
		flags = $urandom;
		if (pick < 50) begin
			size = carried;
			if ($urandom_range(0, 3) == 0)
				carried += $urandom_range(1, 6);
			build_frame(want_magic, want_version, size, flags, carried, '0, FILL_RANDOM);
		end else if (pick < 58) begin
			build_frame(want_magic ^ some_flip(), want_version, carried, flags, carried, '0,
				FILL_RANDOM);
		end else if (pick < 66) begin
			build_frame(want_magic, want_version ^ some_flip(), carried, flags, carried, '0,
				FILL_RANDOM);
		end else if (pick < 76) begin
			size = $urandom_range(0, 1) ? 32'(carried + $urandom_range(1, 16)) : $urandom;
			if (size <= carried)
				size = carried + 1;
			build_frame(want_magic, want_version, size, flags, carried, '0, FILL_RANDOM);
		end else if (pick < 86) begin
			build_frame(want_magic, want_version, carried, flags, carried, some_flip(),
				FILL_RANDOM);
		end else if (pick < 94) begin
			build_noise($urandom_range(1, 27), 1'($urandom_range(0, 1)));
		end else begin
			build_noise($urandom_range(1, 60), 1'b0);
		end
	endtask

	task automatic queue_random_frames(input int unsigned goal_bytes);
		int unsigned start;
		int n;
		start = bytes_queued;
		n = 0;
		while (bytes_queued - start < goal_bytes || n < 4) begin
			queue_random_frame();
			n++;
		end
	endtask

	task automatic wait_drained();
		while (beat_queue.size() != 0 || in_valid || verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == fpv_pkg::REG_MAGIC)
			want_magic = value;
		else
			want_version = value;
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				tx_gap = $urandom_range(0, 17);
				in_valid <= 1'b0;
			end else if (beat_queue.size() > 0) begin
				tx_beat = beat_queue.pop_front();
				data_byte <= tx_beat.data;
				last_byte <= tx_beat.last;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (hold_order) begin
			hold_order = 1'b0;
			rx_hold = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			rx_gap = $urandom_range(0, 17);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			absorb_beat(data_byte, last_byte);
			beats_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (verdicts.size() == 0) begin
				report_mismatch("unexpected result", 32'(status), '0);
			end else begin
				want = verdicts.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (payload_length !== want.length)
					report_mismatch("payload_length", payload_length, want.length);
				if (payload_flags !== want.flags)
					report_mismatch("payload_flags", payload_flags, want.flags);
				if (computed_crc !== want.crc)
					report_mismatch("computed_crc", computed_crc, want.crc);
			end
			status_seen[status]++;
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		clear_frame_state();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset register values, field extremes and every status
		build_frame(want_magic, want_version, 32'd0, 32'd0, 0, '0, FILL_RANDOM);
		build_frame(want_magic, want_version, 32'd8, 32'hFFFFFFFF, 8, '0, FILL_ZERO);
		build_frame(want_magic, want_version, 32'd8, $urandom, 8, '0, FILL_ONES);
		build_frame(want_magic, want_version, 32'd5, $urandom, 9, '0, FILL_RANDOM);
		build_noise(1, 1'b0);
		build_noise(27, 1'b1);
		build_frame(~want_magic, want_version, 32'd3, $urandom, 3, '0, FILL_RANDOM);
		build_frame(want_magic, 32'd0, 32'd3, $urandom, 3, '0, FILL_RANDOM);
		build_frame(want_magic, want_version, 32'hFFFFFFFF, $urandom, 4, '0, FILL_RANDOM);
		build_frame(want_magic, want_version, 32'd6, $urandom, 6, 32'h80000000, FILL_RANDOM);
		build_noise(40, 1'b0);
		wait_drained();

		write_reg(fpv_pkg::REG_MAGIC, 32'h00000000);
		write_reg(fpv_pkg::REG_VERSION, 32'h00000000);
		queue_random_frames(280);
		wait_drained();

		write_reg(fpv_pkg::REG_MAGIC, 32'hFFFFFFFF);
		write_reg(fpv_pkg::REG_VERSION, 32'hFFFFFFFF);
		hold_order = 1'b1;
		for (int i = 0; i < 20; i++)
			build_noise($urandom_range(1, 4), 1'b0);
		queue_random_frames(280);
		wait_drained();

		write_reg(fpv_pkg::REG_MAGIC, $urandom);
		write_reg(fpv_pkg::REG_VERSION, $urandom);
		queue_random_frames(230);
		wait_drained();

		write_reg(fpv_pkg::REG_VERSION, fpv_pkg::VERSION_RESET);
		write_reg(fpv_pkg::REG_MAGIC, fpv_pkg::MAGIC_RESET);
		calm = 1'b1;
		queue_random_frames(180);

		while (beat_queue.size() != 0 || in_valid)
			@(posedge clk);
		for (int n = 0; n < 200 && verdicts.size() != 0; n++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		while (verdicts.size() != 0) begin
			report_mismatch("missing result", '0, '0);
			void'(verdicts.pop_front());
		end

		$display("Covered %0d frames in %0d beats over five register settings, with a long",
			frames_queued, beats_taken);
		$display("receiver stall; statuses: ok %0d short %0d magic %0d version %0d size %0d crc %0d",
			status_seen[fpv_pkg::ST_VALID], status_seen[fpv_pkg::ST_TOO_SHORT],
			status_seen[fpv_pkg::ST_BAD_MAGIC], status_seen[fpv_pkg::ST_BAD_VERSION],
			status_seen[fpv_pkg::ST_SIZE_ERR], status_seen[fpv_pkg::ST_CRC_ERR]);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/fpv_pkg.sv
sv/fpv_in_stage.sv
sv/fpv_checker.sv
sv/framed_payload_validator.sv
test/framed_payload_validator_tb.sv
